@@ src/scfla_pkg.sv @@
package scfla_pkg;

	// handle space
	localparam int NumHandles = 1024;
	localparam int HandleW    = $clog2(NumHandles);
	localparam int CountW     = HandleW + 1;

	// size classes
	localparam int NumClasses = 27;
	localparam int ClassW     = $clog2(NumClasses);
	localparam int FirstLarge = 10;
	localparam int SizeW      = 26;
	localparam int RoundW     = SizeW + 1;
	localparam int SmallLimit = 128;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_TOO_LARGE = 2'd1,
		STAT_NO_MEM    = 2'd2,
		STAT_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_POP
	} state_t;

	typedef struct packed {
		op_t                  opcode;
		logic [SizeW-1:0]     request_bytes;
		logic [HandleW-1:0]   free_handle;
	} cmd_t;

	typedef struct packed {
		logic [HandleW-1:0]   block_handle;
		logic [31:0]          block_offset;
		logic [SizeW-1:0]     class_bytes;
		logic [31:0]          generation;
		status_t              status;
	} res_t;

	// per-handle metadata word
	typedef struct packed {
		logic [31:0]          gen;
		logic                 used;
		logic [ClassW-1:0]    cls;
		logic                 nxt_vld;
		logic [HandleW-1:0]   nxt;
		logic [31:0]          offset;
	} mem_word_t;

	// byte size of a class
	function automatic logic [SizeW-1:0] class_size(input logic [ClassW-1:0] cls);
		logic [SizeW-1:0] sz;
		case (cls)
			5'd0:    sz = SizeW'(16);
			5'd1:    sz = SizeW'(24);
			5'd2:    sz = SizeW'(32);
			5'd3:    sz = SizeW'(40);
			5'd4:    sz = SizeW'(48);
			5'd5:    sz = SizeW'(56);
			5'd6:    sz = SizeW'(64);
			5'd7:    sz = SizeW'(80);
			5'd8:    sz = SizeW'(96);
			5'd9:    sz = SizeW'(128);
			default: sz = SizeW'(1) << (cls - ClassW'(1));
		endcase
		return sz;
	endfunction

	// small classes indexed by rounded size in eighths
	function automatic logic [ClassW-1:0] small_class(input logic [4:0] eighths);
		logic [ClassW-1:0] c;
		case (eighths)
			5'd0, 5'd1, 5'd2: c = ClassW'(0);
			5'd3:             c = ClassW'(1);
			5'd4:             c = ClassW'(2);
			5'd5:             c = ClassW'(3);
			5'd6:             c = ClassW'(4);
			5'd7:             c = ClassW'(5);
			5'd8:             c = ClassW'(6);
			5'd9, 5'd10:      c = ClassW'(7);
			5'd11, 5'd12:     c = ClassW'(8);
			default:          c = ClassW'(9);
		endcase
		return c;
	endfunction

	// rounded size above the largest class
	function automatic logic too_large(input logic [SizeW-1:0] req);
		logic [RoundW-1:0] rnd;
		rnd = (RoundW'(req) + RoundW'(7)) & ~RoundW'(7);
		return rnd > RoundW'(class_size(ClassW'(NumClasses - 1)));
	endfunction

	// class index for a request size
	function automatic logic [ClassW-1:0] class_of(input logic [SizeW-1:0] req);
		logic [RoundW-1:0] rnd;
		logic [ClassW-1:0] c;
		rnd = (RoundW'(req) + RoundW'(7)) & ~RoundW'(7);
		c = ClassW'(NumClasses - 1);
		for (int n = NumClasses - 1; n >= FirstLarge; n--) begin
			if (rnd <= RoundW'(class_size(ClassW'(n))))
				c = ClassW'(n);
		end
		if (rnd <= RoundW'(SmallLimit))
			c = small_class(rnd[7:3]);
		return c;
	endfunction

endpackage

@@ src/size_class_free_list_allocator_core.sv @@
// channel  | signals                        | transfer
// ---------+--------------------------------+---------------------------------
// command  | start, busy, cmd               | beat when start && !busy
// result   | done, result                   | one cycle strobe, no back-pressure
// config   | cfg_valid, cfg_ready, cfg_data | beat when cfg_valid && cfg_ready
//
// A free or an allocation served by the bump pointer passes through S_LOOK
// alone before the next accept; an allocation popped from a free list also
// passes through S_POP, after the metadata memory read of the list head.
// The result strobe comes in the cycle after the last working cycle, from a
// register, and overlaps the next command. Reset clears the list heads, the
// bump pointer and the handle count at once; no clearing pass is needed.
module size_class_free_list_allocator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  scfla_pkg::cmd_t         cmd,
	output logic                    done,
	output scfla_pkg::res_t         result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [31:0]             cfg_data
);
	import scfla_pkg::*;

	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [ClassW-1:0]      cls_q;
	logic                   big_q;
	logic [HandleW-1:0]     hdl_q;
	logic [31:0]            limit_q;
	logic [31:0]            bump_q;
	logic [CountW-1:0]      issued_q;
	logic                   head_vld_q [NumClasses];
	logic [HandleW-1:0]     head_hdl_q [NumClasses];
	mem_word_t              blk_mem [NumHandles];
	mem_word_t              rd_q;
	logic                   done_q;
	res_t                   res_q;

	logic                   latch;
	logic                   pop_start;
	logic [HandleW-1:0]     rd_addr;
	logic                   wr_en;
	logic [HandleW-1:0]     wr_addr;
	mem_word_t              wr_data;
	logic                   hd_we;
	logic [ClassW-1:0]      hd_idx;
	logic                   hd_vld;
	logic [HandleW-1:0]     hd_hdl;
	logic                   bump_we;
	logic                   done_d;
	res_t                   res_d;
	logic [SizeW-1:0]       csize;
	logic [SizeW-1:0]       fsize;
	logic                   no_mem;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	assign csize  = class_size(cls_q);
	assign fsize  = class_size(rd_q.cls);
	assign no_mem = (issued_q >= CountW'(NumHandles))
		|| ((33'(bump_q) + 33'(csize)) > 33'(limit_q));

	// next state, memory and list head updates, result
	always_comb begin
		state_d   = state_q;
		latch     = 1'b0;
		pop_start = 1'b0;
		rd_addr   = cmd.free_handle;
		wr_en     = 1'b0;
		wr_addr   = hdl_q;
		wr_data   = rd_q;
		hd_we     = 1'b0;
		hd_idx    = cls_q;
		hd_vld    = 1'b0;
		hd_hdl    = hdl_q;
		bump_we   = 1'b0;
		done_d    = 1'b0;
		res_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					latch   = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_IDLE;
				if (op_q == OP_ALLOC) begin
					if (big_q) begin
						done_d       = 1'b1;
						res_d.status = STAT_TOO_LARGE;
					end else if (head_vld_q[cls_q]) begin
						// read the list head's metadata
						rd_addr   = head_hdl_q[cls_q];
						pop_start = 1'b1;
						state_d   = S_POP;
					end else if (no_mem) begin
						done_d       = 1'b1;
						res_d.status = STAT_NO_MEM;
					end else begin
						// fresh block from the bump pointer
						wr_en           = 1'b1;
						wr_addr         = issued_q[HandleW-1:0];
						wr_data.gen     = '0;
						wr_data.used    = 1'b1;
						wr_data.cls     = cls_q;
						wr_data.nxt_vld = 1'b0;
						wr_data.nxt     = '0;
						wr_data.offset  = bump_q;
						bump_we         = 1'b1;
						done_d             = 1'b1;
						res_d.block_handle = issued_q[HandleW-1:0];
						res_d.block_offset = bump_q;
						res_d.class_bytes  = csize;
						res_d.generation   = '0;
						res_d.status       = STAT_OK;
					end
				end else begin
					if ((CountW'(hdl_q) >= issued_q) || !rd_q.used) begin
						done_d       = 1'b1;
						res_d.status = STAT_BAD_FREE;
					end else begin
						// push the block on its class list
						wr_en           = 1'b1;
						wr_data.gen     = rd_q.gen + 32'd1;
						wr_data.used    = 1'b0;
						wr_data.nxt_vld = head_vld_q[rd_q.cls];
						wr_data.nxt     = head_hdl_q[rd_q.cls];
						hd_we           = 1'b1;
						hd_idx          = rd_q.cls;
						hd_vld          = 1'b1;
						hd_hdl          = hdl_q;
						done_d             = 1'b1;
						res_d.block_handle = hdl_q;
						res_d.block_offset = rd_q.offset;
						res_d.class_bytes  = fsize;
						res_d.generation   = rd_q.gen + 32'd1;
						res_d.status       = STAT_OK;
					end
				end
			end
			S_POP: begin
				// unlink the head and mark it in use
				state_d         = S_IDLE;
				wr_en           = 1'b1;
				wr_data.used    = 1'b1;
				wr_data.cls     = cls_q;
				hd_we           = 1'b1;
				hd_vld          = rd_q.nxt_vld;
				hd_hdl          = rd_q.nxt;
				done_d             = 1'b1;
				res_d.block_handle = hdl_q;
				res_d.block_offset = rd_q.offset;
				res_d.class_bytes  = csize;
				res_d.generation   = rd_q.gen;
				res_d.status       = STAT_OK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state machine and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			limit_q  <= 32'd67108864;
			bump_q   <= '0;
			issued_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
			if (bump_we) begin
				bump_q   <= bump_q + 32'(csize);
				issued_q <= issued_q + CountW'(1);
			end
		end
	end

	// list head valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumClasses; i++)
				head_vld_q[i] <= 1'b0;
		end else if (hd_we) begin
			head_vld_q[hd_idx] <= hd_vld;
		end
	end

	// list head handles and command fields
	always_ff @(posedge clk) begin
		if (hd_we)
			head_hdl_q[hd_idx] <= hd_hdl;
		if (latch) begin
			op_q  <= cmd.opcode;
			cls_q <= class_of(cmd.request_bytes);
			big_q <= too_large(cmd.request_bytes);
			hdl_q <= cmd.free_handle;
		end else if (pop_start) begin
			hdl_q <= head_hdl_q[cls_q];
		end
		res_q <= res_d;
	end

	// block metadata memory
	always_ff @(posedge clk) begin
		if (wr_en)
			blk_mem[wr_addr] <= wr_data;
		rd_q <= blk_mem[rd_addr];
	end

endmodule
